// ----- hdl/vrv_pkg.sv -----
// shared types and constants for the viewshed ray visibility block
`default_nettype none

package vrv_pkg;

    localparam int RAY_W   = 12;
    localparam int ELEV_W  = 20;
    localparam int DIST_W  = 24;
    localparam int RISE_W  = ELEV_W + 1;
    localparam int PROD_W  = RISE_W + DIST_W + 1;

    // 2000 m eye height in 1/16 m
    localparam logic signed [ELEV_W-1:0] VIEW_HEIGHT_RESET = 20'sd32000;

    typedef struct packed {
        logic                     seen;
        logic signed [RISE_W-1:0] rise;
        logic [DIST_W-1:0]        distance;
    } t_ray_entry;

endpackage

`default_nettype wire

// ----- hdl/vrv_if.sv -----
// stream interfaces for terrain samples and visibility results
`default_nettype none

interface vrv_sample_if
    import vrv_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [RAY_W-1:0]         ray;
    logic                     first_of_ray;
    logic signed [ELEV_W-1:0] elevation;
    logic [DIST_W-1:0]        distance;

    modport source (output valid, output ray, output first_of_ray, output elevation,
                    output distance, input ready);
    modport sink   (input valid, input ray, input first_of_ray, input elevation,
                    input distance, output ready);
endinterface

interface vrv_result_if
    import vrv_pkg::*;
;
    logic             valid;
    logic             ready;
    logic             visible;
    logic [RAY_W-1:0] ray_out;

    modport source (output valid, output visible, output ray_out, input ready);
    modport sink   (input valid, input visible, input ray_out, output ready);
endinterface

`default_nettype wire

// ----- hdl/viewshed_ray_visibility.sv -----
// viewshed visibility along rays: per-ray steepest angle kept in one memory
//
// Samples arrive on i_sample (valid/ready), one beat per terrain sample, tagged
// with its ray. Each sample gives one beat on o_result: visible and the ray.
// The user must write view_height through i_cfg_we / i_cfg_wdata only while the
// block is idle; the block does not enforce this. From the accepting edge to
// o_result.valid the memory is read at the accepting edge, then come the product
// stage and compare/write-back into the output register. Throughput is one sample
// per cycle while o_result is not stalled, also for back-to-back samples on the
// same ray; the per-ray memory is read once and written at most once per sample,
// and the entry still in flight is forwarded (two product pairs are formed in
// parallel). Out-of-range rays (ray >= RAY_COUNT) touch no state and report not
// visible. After reset a clearing pass writes every memory entry with
// i_sample.ready low; view_height returns to 2000 m at reset. When o_result is
// stalled the whole pipeline holds and i_sample.ready drops only if the output
// register is full; a pending result never blocks a free input stage otherwise.
`default_nettype none

module viewshed_ray_visibility
    import vrv_pkg::*;
#(
    parameter int RAY_COUNT = 4096
) (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_cfg_we,
    input  wire logic signed [ELEV_W-1:0] i_cfg_wdata,
    vrv_sample_if.sink               i_sample,
    vrv_result_if.source             o_result
);

    localparam int AW = (RAY_COUNT > 1) ? $clog2(RAY_COUNT) : 1;
    localparam logic [AW-1:0] CLR_LAST = AW'(RAY_COUNT - 1);

    // per-ray state
    t_ray_entry r_mem [RAY_COUNT];
    t_ray_entry r_rd_q;

    logic signed [ELEV_W-1:0] r_view_height;
    logic                     r_clearing;
    logic [AW-1:0]            r_clr_addr;

    // write-back copy of the entry written at the last advance
    logic                     r_wb_valid;
    logic [AW-1:0]            r_wb_addr;
    t_ray_entry               r_wb_entry;

    // stage 1: memory read data arrives
    logic                     r_s1_valid;
    logic [RAY_W-1:0]         r_s1_ray;
    logic                     r_s1_inr;
    logic                     r_s1_first;
    logic signed [RISE_W-1:0] r_s1_rise;
    logic [DIST_W-1:0]        r_s1_dist;

    // stage 2: products registered, compare and write-back
    logic                     r_s2_valid;
    logic [RAY_W-1:0]         r_s2_ray;
    logic                     r_s2_inr;
    logic                     r_s2_first;
    logic signed [RISE_W-1:0] r_s2_rise;
    logic [DIST_W-1:0]        r_s2_dist;
    logic                     r_s2_base_seen;
    logic                     r_s2_fwd;
    logic signed [PROD_W-1:0] r_s2_base_l;
    logic signed [PROD_W-1:0] r_s2_base_r;
    logic signed [PROD_W-1:0] r_s2_fwd_l;
    logic signed [PROD_W-1:0] r_s2_fwd_r;

    // outcome of the item that left stage 2 at the last advance
    logic r_prv_store;
    logic r_prv_wr;

    logic             r_out_valid;
    logic             r_vis;
    logic [RAY_W-1:0] r_out_ray;

    logic                     adv;
    logic                     in_acc;
    logic [AW-1:0]            in_addr;
    logic                     in_inr;
    logic signed [RISE_W-1:0] in_rise;

    logic [AW-1:0]            s1_addr;
    logic [AW-1:0]            s2_addr;
    t_ray_entry               s1_base;
    logic                     s1_fwd;
    logic signed [PROD_W-1:0] s1_base_l;
    logic signed [PROD_W-1:0] s1_base_r;
    logic signed [PROD_W-1:0] s1_fwd_l;
    logic signed [PROD_W-1:0] s1_fwd_r;

    logic                     s2_seen;
    logic signed [PROD_W-1:0] s2_l;
    logic signed [PROD_W-1:0] s2_r;
    logic                     s2_vis;
    logic                     s2_store;
    logic                     s2_wr;
    t_ray_entry               s2_entry;

    assign adv     = !r_out_valid || o_result.ready;
    assign i_sample.ready = adv && !r_clearing;
    assign in_acc  = i_sample.valid && i_sample.ready;
    assign in_addr = AW'(i_sample.ray);
    assign in_inr  = 32'(i_sample.ray) < RAY_COUNT;
    assign in_rise = RISE_W'(i_sample.elevation) - RISE_W'(r_view_height);

    assign s1_addr = AW'(r_s1_ray);
    assign s2_addr = AW'(r_s2_ray);

    // stage 1: pick the stored entry, speculate on the item ahead
    always_comb begin
        s1_base = (r_wb_valid && r_wb_addr == s1_addr) ? r_wb_entry : r_rd_q;
        s1_fwd  = r_s2_valid && r_s2_inr && r_s1_inr && (s2_addr == s1_addr);
        s1_base_l = r_s1_rise * $signed({1'b0, s1_base.distance});
        s1_base_r = s1_base.rise * $signed({1'b0, r_s1_dist});
        s1_fwd_l  = r_s1_rise * $signed({1'b0, r_s2_dist});
        s1_fwd_r  = r_s2_rise * $signed({1'b0, r_s1_dist});
    end

    // stage 2: resolve which entry applied, then compare
    always_comb begin
        priority if (r_s2_first) begin
            s2_seen = 1'b0;
            s2_l    = r_s2_base_l;
            s2_r    = r_s2_base_r;
        end else if (r_s2_fwd && r_prv_store) begin
            s2_seen = 1'b1;
            s2_l    = r_s2_fwd_l;
            s2_r    = r_s2_fwd_r;
        end else if (r_s2_fwd && r_prv_wr) begin
            s2_seen = 1'b0;
            s2_l    = r_s2_base_l;
            s2_r    = r_s2_base_r;
        end else begin
            s2_seen = r_s2_base_seen;
            s2_l    = r_s2_base_l;
            s2_r    = r_s2_base_r;
        end

        priority if (!r_s2_inr) begin
            s2_vis = 1'b0;
        end else if (r_s2_dist == '0) begin
            s2_vis = 1'b1;
        end else if (!s2_seen) begin
            s2_vis = 1'b1;
        end else begin
            s2_vis = s2_l > s2_r;
        end

        s2_store = r_s2_valid && r_s2_inr && (r_s2_dist != '0) && s2_vis;
        s2_wr    = r_s2_valid && r_s2_inr && (s2_store || r_s2_first);

        s2_entry.seen     = s2_store;
        s2_entry.rise     = r_s2_rise;
        s2_entry.distance = r_s2_dist;
    end

    // per-ray memory: one write port, one registered read port (old data on collision)
    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            r_mem[r_clr_addr] <= '0;
        end else if (adv && s2_wr) begin
            r_mem[s2_addr] <= s2_entry;
        end
        if (in_acc) begin
            r_rd_q <= r_mem[in_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_view_height <= VIEW_HEIGHT_RESET;
            r_clearing    <= 1'b1;
            r_clr_addr    <= '0;
            r_wb_valid    <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_s2_valid    <= 1'b0;
            r_prv_store   <= 1'b0;
            r_prv_wr      <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_view_height <= i_cfg_wdata;
            end
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == CLR_LAST) begin
                    r_clearing <= 1'b0;
                end
            end
            if (adv) begin
                r_wb_valid  <= s2_wr;
                r_s1_valid  <= in_acc;
                r_s2_valid  <= r_s1_valid;
                r_prv_store <= s2_store;
                r_prv_wr    <= s2_wr;
                r_out_valid <= r_s2_valid;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_wb_addr  <= s2_addr;
            r_wb_entry <= s2_entry;

            r_s1_ray   <= i_sample.ray;
            r_s1_inr   <= in_inr;
            r_s1_first <= i_sample.first_of_ray;
            r_s1_rise  <= in_rise;
            r_s1_dist  <= i_sample.distance;

            r_s2_ray       <= r_s1_ray;
            r_s2_inr       <= r_s1_inr;
            r_s2_first     <= r_s1_first;
            r_s2_rise      <= r_s1_rise;
            r_s2_dist      <= r_s1_dist;
            r_s2_base_seen <= s1_base.seen;
            r_s2_fwd       <= s1_fwd;
            r_s2_base_l    <= s1_base_l;
            r_s2_base_r    <= s1_base_r;
            r_s2_fwd_l     <= s1_fwd_l;
            r_s2_fwd_r     <= s1_fwd_r;

            r_vis     <= s2_vis;
            r_out_ray <= r_s2_ray;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.visible = r_vis;
    assign o_result.ray_out = r_out_ray;

    // out-of-range rays never write state
    a_no_write_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_inr) |-> !s2_wr)
        else $error("write issued for out-of-range ray");

    // observer cell on an in-range ray is always reported visible
    a_observer_visible: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv && r_s2_valid && r_s2_inr && r_s2_dist == '0) |=> r_vis)
        else $error("observer cell not reported visible");

    // clearing pass ends after the last entry
    a_clear_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_clearing && r_clr_addr == CLR_LAST) |=> !r_clearing)
        else $error("clearing pass did not end");

    // no sample taken while the memory is being cleared
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |-> !in_acc && !r_s1_valid && !r_s2_valid)
        else $error("sample in flight during clearing pass");

endmodule

`default_nettype wire

// ----- tb/vrv_checker.sv -----
// checker for viewshed ray visibility: watches sample and result beats, predicts and compares
`default_nettype none

module vrv_checker
    import vrv_pkg::*;
#(
    parameter int RAY_COUNT = 4096
) (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_cfg_we,
    input  wire logic signed [ELEV_W-1:0] i_cfg_wdata,
    vrv_sample_if                         smp,
    vrv_result_if                         res,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        logic             visible;
        logic [RAY_W-1:0] ray;
    } t_sight;

    t_sight                   sight_q[$];
    bit                       ray_seen [RAY_COUNT];
    logic signed [RISE_W-1:0] best_rise [RAY_COUNT];
    logic [DIST_W-1:0]        best_dist [RAY_COUNT];
    logic signed [ELEV_W-1:0] eye_height;
    int                       fails = 0;

    function automatic t_sight predict_sight(input logic [RAY_W-1:0] ray,
                                             input logic first,
                                             input logic signed [ELEV_W-1:0] elev,
                                             input logic [DIST_W-1:0] gnd_dist);
        t_sight                   s;
        logic signed [RISE_W-1:0] rise;
        bit                       seen;
        longint                   lhs;
        longint                   rhs;
        s.ray     = ray;
        s.visible = 1'b0;
        rise      = elev - eye_height;
        if (int'(ray) < RAY_COUNT) begin
            seen = first ? 1'b0 : ray_seen[ray];
            if (first) begin
                ray_seen[ray] = 1'b0;
            end
            if (gnd_dist == '0) begin
                // observer cell: always seen, state untouched
                s.visible = 1'b1;
            end else begin
                if (!seen) begin
                    s.visible = 1'b1;
                end else begin
                    // exact angle compare by cross products
                    lhs = longint'(rise) * longint'(best_dist[ray]);
                    rhs = longint'(best_rise[ray]) * longint'(gnd_dist);
                    s.visible = lhs > rhs;
                end
                if (s.visible) begin
                    ray_seen[ray]  = 1'b1;
                    best_rise[ray] = rise;
                    best_dist[ray] = gnd_dist;
                end
            end
        end
        return s;
    endfunction

    always @(posedge i_clk) begin
        t_sight want;
        if (!i_rst_n) begin
            foreach (ray_seen[k]) begin
                ray_seen[k] = 1'b0;
            end
            eye_height = VIEW_HEIGHT_RESET;
            sight_q.delete();
        end else begin
            if (i_cfg_we) begin
                eye_height = i_cfg_wdata;
            end
            if (res.valid && res.ready) begin
                if (sight_q.size() == 0) begin
                    $error("result beat with no sample pending: ray_out %0d", res.ray_out);
                    fails++;
                end else begin
                    want = sight_q.pop_front();
                    if (res.visible !== want.visible) begin
                        $error("visible: expected %0b, actual %0b (ray %0d)",
                               want.visible, res.visible, want.ray);
                        fails++;
                    end
                    if (res.ray_out !== want.ray) begin
                        $error("ray_out: expected %0d, actual %0d", want.ray, res.ray_out);
                        fails++;
                    end
                end
            end
            if (smp.valid && smp.ready) begin
                sight_q.push_back(predict_sight(smp.ray, smp.first_of_ray,
                                                smp.elevation, smp.distance));
            end
        end
        o_pending    <= sight_q.size();
        o_fail_count <= fails;
    end

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// testbench top for viewshed ray visibility: clock, reset, stimulus and verdict
`default_nettype none

module tb_top;
    import vrv_pkg::*;

    localparam logic signed [ELEV_W-1:0] ELEV_MAX = 20'sh7FFFF;
    localparam logic signed [ELEV_W-1:0] ELEV_MIN = 20'sh80000;
    localparam logic [DIST_W-1:0]        DIST_MAX = 24'hFFFFFF;
    localparam int                       LANES    = 4;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic signed [ELEV_W-1:0] i_cfg_wdata;
    logic signed [ELEV_W-1:0] eye_now;
    bit                       steady;
    int                       fail_count;
    int                       pending;

    vrv_sample_if smp();
    vrv_result_if res();

    viewshed_ray_visibility #(
        .RAY_COUNT (4096)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (smp),
        .o_result    (res)
    );

    vrv_checker #(
        .RAY_COUNT (4096)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .smp          (smp),
        .res          (res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #5 i_clk = ~i_clk;

    // result side back-pressure
    always @(posedge i_clk) begin
        res.ready <= steady || ($urandom_range(99) >= 18);
    end

    task automatic put_sample(input logic [RAY_W-1:0] ray, input logic first,
                              input logic signed [ELEV_W-1:0] elev,
                              input logic [DIST_W-1:0] gnd_dist);
        if (!steady && $urandom_range(99) < 15) begin
            smp.valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge i_clk);
        end
        smp.valid        <= 1'b1;
        smp.ray          <= ray;
        smp.first_of_ray <= first;
        smp.elevation    <= elev;
        smp.distance     <= gnd_dist;
        do @(posedge i_clk); while (!smp.ready);
    endtask

    // drop valid and wait until every sample has its result beat
    task automatic settle();
        smp.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_eye(input logic signed [ELEV_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        eye_now     = value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // mostly rays walked outward with random slopes, some raw noise beats
    task automatic random_phase(input int count);
        logic [RAY_W-1:0]         lane_ray  [LANES];
        logic [DIST_W-1:0]        lane_dist [LANES];
        logic signed [ELEV_W-1:0] lane_elev [LANES];
        bit                       fresh     [LANES];
        int                       i;
        int                       k;
        int                       lift;
        logic                     first;
        for (k = 0; k < LANES; k++) begin
            fresh[k] = 1'b1;
        end
        for (i = 0; i < count; i++) begin
            k = $urandom_range(LANES - 1);
            if ($urandom_range(99) < 15) begin
                put_sample(RAY_W'($urandom), 1'($urandom_range(1)),
                           ELEV_W'($urandom), DIST_W'($urandom));
            end else if (!fresh[k] && $urandom_range(99) < 5) begin
                // same angle as the lane's last sample: never strictly steeper
                put_sample(lane_ray[k], 1'b0, lane_elev[k], lane_dist[k]);
            end else begin
                if (fresh[k] || $urandom_range(99) < 4) begin
                    lane_ray[k]  = $urandom_range(1) ? RAY_W'($urandom_range(15))
                                                     : RAY_W'($urandom);
                    lane_dist[k] = DIST_W'($urandom_range(0, 64));
                    fresh[k]     = 1'b0;
                    first        = 1'b1;
                end else begin
                    lane_dist[k] = lane_dist[k] + DIST_W'($urandom_range(1, 2000));
                    first        = 1'b0;
                end
                lift = (int'(lane_dist[k]) * (int'($urandom_range(0, 200)) - 100)) / 64;
                lane_elev[k] = ELEV_W'(int'(eye_now) + lift);
                put_sample(lane_ray[k], first, lane_elev[k], lane_dist[k]);
            end
        end
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_wdata      = '0;
        eye_now          = VIEW_HEIGHT_RESET;
        steady           = 1'b0;
        smp.valid        = 1'b0;
        smp.ray          = '0;
        smp.first_of_ray = 1'b0;
        smp.elevation    = '0;
        smp.distance     = '0;
        res.ready        = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed part at the reset eye height
        put_sample(0, 1'b1, 0, 0);
        put_sample(0, 1'b0, 32016, 16);
        put_sample(0, 1'b0, 32032, 32);
        put_sample(0, 1'b0, 32000, 48);
        put_sample(0, 1'b0, 32100, 64);
        put_sample(0, 1'b0, 0, 0);
        put_sample(0, 1'b0, 32100, 64);
        put_sample(0, 1'b1, 31000, 100);
        put_sample(4095, 1'b1, ELEV_MAX, DIST_MAX);
        put_sample(4095, 1'b0, ELEV_MIN, 1);
        put_sample(4095, 1'b0, ELEV_MAX, 1);
        put_sample(4095, 1'b1, ELEV_MIN, 0);
        put_sample(4095, 1'b0, ELEV_MIN, DIST_MAX);
        put_sample(7, 1'b0, 0, 5);
        put_sample(7, 1'b0, 0, 6);
        put_sample(1, 1'b1, 40000, 1000);
        put_sample(2, 1'b1, 20000, 1000);
        put_sample(1, 1'b0, 39000, 2000);
        put_sample(2, 1'b0, 20000, 1001);
        put_sample(2048, 1'b1, ELEV_MAX, 1);
        put_sample(2048, 1'b0, ELEV_MAX, 1);
        settle();

        write_eye(ELEV_MIN);
        put_sample(9, 1'b1, ELEV_MAX, 1);
        put_sample(9, 1'b0, ELEV_MIN, DIST_MAX);
        random_phase(400);
        settle();

        write_eye(ELEV_MAX);
        put_sample(9, 1'b1, ELEV_MIN, 1);
        put_sample(9, 1'b0, ELEV_MAX, DIST_MAX);
        random_phase(400);
        settle();

        // no idling on either side for this stretch
        steady = 1'b1;
        write_eye(0);
        random_phase(400);
        settle();
        steady = 1'b0;

        write_eye(ELEV_W'($urandom));
        random_phase(360);
        settle();

        write_eye(ELEV_W'($urandom));
        random_phase(360);
        settle();

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
